// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the blink envelope generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/beg_pkg.sv =====
// Package of the blink envelope generator: types, constants and the microcode table.
`default_nettype none

package beg_pkg;

	// Field widths.
	localparam int unsigned LID_W   = 16;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned IVL_W   = 24;
	localparam int unsigned TIMER_W = 26;
	localparam int unsigned PHASE_W = 18;
	localparam int unsigned RNG_W   = 32;

	localparam logic [RNG_W-1:0] GOLDEN_SEED = 32'h9E3779B9;
	localparam logic [LID_W-1:0] LID_FULL    = 16'hFFFF;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ENABLE = 3'd0;
	localparam cfg_idx_t CFG_SEED   = 3'd1;
	localparam cfg_idx_t CFG_MIN    = 3'd2;
	localparam cfg_idx_t CFG_SPAN   = 3'd3;
	localparam cfg_idx_t CFG_CLOSE  = 3'd4;
	localparam cfg_idx_t CFG_HOLD   = 3'd5;
	localparam cfg_idx_t CFG_OPEN   = 3'd6;

	// Register values after reset.
	localparam logic [IVL_W-1:0]  RST_MIN   = 24'd2000;
	localparam logic [IVL_W-1:0]  RST_SPAN  = 24'd4000;
	localparam logic [TICK_W-1:0] RST_CLOSE = 16'd80;
	localparam logic [TICK_W-1:0] RST_HOLD  = 16'd40;
	localparam logic [TICK_W-1:0] RST_OPEN  = 16'd120;

	// Divider iteration count: one quotient bit per step.
	typedef logic [3:0] div_cnt_t;
	localparam div_cnt_t DIV_LAST = 4'd15;

	typedef logic [3:0] pc_t;
	typedef logic [3:0] op_t;
	typedef logic [2:0] cond_t;

	// Datapath operations.
	localparam op_t OP_IDLE   = 4'd0;
	localparam op_t OP_NOP    = 4'd1;
	localparam op_t OP_ADV    = 4'd2;
	localparam op_t OP_SETUP  = 4'd3;
	localparam op_t OP_DIV    = 4'd4;
	localparam op_t OP_FIN    = 4'd5;
	localparam op_t OP_OUT    = 4'd6;
	localparam op_t OP_XS     = 4'd7;
	localparam op_t OP_MUL    = 4'd8;
	localparam op_t OP_ADDMIN = 4'd9;

	// Jump conditions.
	localparam cond_t C_NEVER   = 3'd0;
	localparam cond_t C_ALWAYS  = 3'd1;
	localparam cond_t C_END     = 3'd2;
	localparam cond_t C_NOBLINK = 3'd3;
	localparam cond_t C_HOLD    = 3'd4;
	localparam cond_t C_DIVMORE = 3'd5;
	localparam cond_t C_OUTBUSY = 3'd6;
	localparam cond_t C_ITEM    = 3'd7;

	// Program addresses.
	localparam pc_t ADDR_IDLE  = 4'd0;
	localparam pc_t ADDR_ADV   = 4'd1;
	localparam pc_t ADDR_ENDCK = 4'd2;
	localparam pc_t ADDR_BLKCK = 4'd3;
	localparam pc_t ADDR_SETUP = 4'd4;
	localparam pc_t ADDR_DIV   = 4'd5;
	localparam pc_t ADDR_FIN   = 4'd6;
	localparam pc_t ADDR_OUT   = 4'd7;
	localparam pc_t ADDR_RET   = 4'd8;
	localparam pc_t ADDR_XS    = 4'd9;
	localparam pc_t ADDR_MUL   = 4'd10;
	localparam pc_t ADDR_ADD   = 4'd11;
	localparam pc_t ADDR_DRET  = 4'd12;

	// One control word: the operation, a jump condition and its target.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// Configuration registers seen by the datapath.
	typedef struct packed {
		logic              enable;
		logic [IVL_W-1:0]  min_ivl;
		logic [IVL_W-1:0]  span;
		logic [TICK_W-1:0] close_t;
		logic [TICK_W-1:0] hold_t;
		logic [TICK_W-1:0] open_t;
	} cfg_t;

	// Sequencer to datapath controls.
	typedef struct packed {
		op_t              op;
		logic             out_load;
		logic             in_load;
		logic             seed_load;
		logic             abort;
		logic [RNG_W-1:0] seed;
	} ctrl_t;

	// Datapath to sequencer status.
	typedef struct packed {
		logic in_blink;
		logic end_blink;
		logic hold;
		logic div_more;
	} stat_t;

	// Microprogram. A taken jump goes to the target, otherwise to the next word.
	function automatic ucode_t ucode_rom(input pc_t addr);
		ucode_t w;
		case (addr)
			ADDR_IDLE:  w = '{op: OP_IDLE,   cond: C_NEVER,   target: ADDR_IDLE};
			ADDR_ADV:   w = '{op: OP_ADV,    cond: C_NEVER,   target: ADDR_IDLE};
			ADDR_ENDCK: w = '{op: OP_NOP,    cond: C_END,     target: ADDR_XS};
			ADDR_BLKCK: w = '{op: OP_NOP,    cond: C_NOBLINK, target: ADDR_OUT};
			ADDR_SETUP: w = '{op: OP_SETUP,  cond: C_HOLD,    target: ADDR_OUT};
			ADDR_DIV:   w = '{op: OP_DIV,    cond: C_DIVMORE, target: ADDR_DIV};
			ADDR_FIN:   w = '{op: OP_FIN,    cond: C_NEVER,   target: ADDR_IDLE};
			ADDR_OUT:   w = '{op: OP_OUT,    cond: C_OUTBUSY, target: ADDR_OUT};
			ADDR_RET:   w = '{op: OP_NOP,    cond: C_ALWAYS,  target: ADDR_IDLE};
			ADDR_XS:    w = '{op: OP_XS,     cond: C_NEVER,   target: ADDR_IDLE};
			ADDR_MUL:   w = '{op: OP_MUL,    cond: C_NEVER,   target: ADDR_IDLE};
			ADDR_ADD:   w = '{op: OP_ADDMIN, cond: C_ITEM,    target: ADDR_OUT};
			ADDR_DRET:  w = '{op: OP_NOP,    cond: C_ALWAYS,  target: ADDR_IDLE};
			default:    w = '{op: OP_NOP,    cond: C_ALWAYS,  target: ADDR_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/beg_datapath.sv =====
// Datapath of the blink envelope generator: generator, timers, serial divider, lid merge.
`default_nettype none

module beg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire beg_pkg::ctrl_t                ctrl,
	input  wire beg_pkg::cfg_t                 cfg,
	input  wire logic [beg_pkg::TICK_W-1:0]    delta_ticks,
	input  wire logic [beg_pkg::LID_W-1:0]     left_lid_in,
	input  wire logic [beg_pkg::LID_W-1:0]     right_lid_in,
	input  wire logic                          left_clip_driven,
	input  wire logic                          right_clip_driven,
	output beg_pkg::stat_t                     stat,
	output logic [beg_pkg::LID_W-1:0]          left_lid_out,
	output logic [beg_pkg::LID_W-1:0]          right_lid_out,
	output logic [beg_pkg::LID_W-1:0]          closure,
	output logic                               blinking,
	output logic                               made_active
);

	// Latched input word.
	logic [beg_pkg::TICK_W-1:0] delta_q;
	logic [beg_pkg::LID_W-1:0]  left_q;
	logic [beg_pkg::LID_W-1:0]  right_q;
	logic                       ldrv_q;
	logic                       rdrv_q;

	// Envelope state.
	logic [beg_pkg::RNG_W-1:0]   rng_q;
	logic [47:0]                 prod_q;
	logic [beg_pkg::TIMER_W-1:0] idle_q;
	logic [beg_pkg::PHASE_W-1:0] phase_q;
	logic                        in_blink_q;
	logic                        end_q;

	// Divider and closure.
	logic [beg_pkg::LID_W-1:0] rem_q;
	logic [beg_pkg::LID_W-1:0] quot_q;
	logic                      open_q;
	beg_pkg::div_cnt_t         cnt_q;
	logic [beg_pkg::LID_W-1:0] closure_q;

	// Result word.
	logic [beg_pkg::LID_W-1:0] lout_q;
	logic [beg_pkg::LID_W-1:0] rout_q;
	logic [beg_pkg::LID_W-1:0] cout_q;
	logic                      blink_out_q;
	logic                      active_q;

	logic [beg_pkg::PHASE_W-1:0] total;
	logic [beg_pkg::PHASE_W-1:0] close_hold;
	logic [beg_pkg::PHASE_W-1:0] phase_sum;
	logic [beg_pkg::PHASE_W-1:0] open_x;
	logic                        in_close;
	logic [beg_pkg::TIMER_W-1:0] delta_ext;
	logic [beg_pkg::RNG_W-1:0]   xs1;
	logic [beg_pkg::RNG_W-1:0]   xs2;
	logic [beg_pkg::RNG_W-1:0]   xs3;
	logic [47:0]                 prod_c;
	logic [beg_pkg::LID_W-1:0]   divisor;
	logic [beg_pkg::LID_W:0]     shifted;
	logic [beg_pkg::LID_W:0]     diff;
	logic                        ge;
	logic [beg_pkg::LID_W-1:0]   neg_q;

	// Ramp boundaries and phase advance.
	assign total      = {2'b00, cfg.close_t} + {2'b00, cfg.hold_t} + {2'b00, cfg.open_t};
	assign close_hold = {2'b00, cfg.close_t} + {2'b00, cfg.hold_t};
	assign phase_sum  = phase_q + {2'b00, delta_q};
	assign open_x     = phase_q - close_hold;
	assign in_close   = phase_q < {2'b00, cfg.close_t};
	assign delta_ext  = {{(beg_pkg::TIMER_W-beg_pkg::TICK_W){1'b0}}, delta_q};

	// One xorshift draw with shifts 13, 17 and 5.
	assign xs1 = rng_q ^ (rng_q << 13);
	assign xs2 = xs1 ^ (xs1 >> 17);
	assign xs3 = xs2 ^ (xs2 << 5);

	// Interval scaling product of the low 24 generator bits and the span.
	assign prod_c = {24'd0, rng_q[23:0]} * {24'd0, cfg.span};

	// One restoring division step.
	assign divisor = open_q ? cfg.open_t : cfg.close_t;
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = shifted >= {1'b0, divisor};
	assign neg_q   = ~quot_q + 16'd1;

	// Status for the sequencer's jumps.
	assign stat.in_blink  = in_blink_q;
	assign stat.end_blink = end_q;
	assign stat.hold      = !in_close && (phase_q < close_hold);
	assign stat.div_more  = cnt_q != beg_pkg::DIV_LAST;

	// Input word latch.
	always_ff @(posedge clk) begin
		if (ctrl.in_load) begin
			delta_q <= delta_ticks;
			left_q  <= left_lid_in;
			right_q <= right_lid_in;
			ldrv_q  <= left_clip_driven;
			rdrv_q  <= right_clip_driven;
		end
	end

	// Generator word, timers and blink state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q      <= beg_pkg::GOLDEN_SEED;
			phase_q    <= '0;
			in_blink_q <= 1'b0;
			end_q      <= 1'b0;
		end else begin
			if (ctrl.seed_load) begin
				rng_q <= (ctrl.seed == '0) ? beg_pkg::GOLDEN_SEED : ctrl.seed;
			end
			if (ctrl.abort) begin
				in_blink_q <= 1'b0;
				phase_q    <= '0;
			end
			case (ctrl.op)
				beg_pkg::OP_ADV: begin
					if (cfg.enable) begin
						if (in_blink_q) begin
							if (phase_sum >= total) begin
								in_blink_q <= 1'b0;
								phase_q    <= '0;
								end_q      <= 1'b1;
							end else begin
								phase_q <= phase_sum;
							end
						end else if (delta_ext >= idle_q) begin
							in_blink_q <= 1'b1;
							phase_q    <= '0;
						end
					end
				end
				beg_pkg::OP_XS: begin
					rng_q <= xs3;
				end
				beg_pkg::OP_ADDMIN: begin
					end_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Idle timer, product, divider and closure registers.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			beg_pkg::OP_ADV: begin
				closure_q <= '0;
				if (cfg.enable && !in_blink_q) begin
					if (delta_ext >= idle_q) begin
						idle_q <= '0;
					end else begin
						idle_q <= idle_q - delta_ext;
					end
				end
			end
			beg_pkg::OP_MUL: begin
				prod_q <= prod_c;
			end
			beg_pkg::OP_ADDMIN: begin
				idle_q <= {2'b00, cfg.min_ivl} + {2'b00, prod_q[47:24]};
			end
			beg_pkg::OP_SETUP: begin
				cnt_q  <= '0;
				quot_q <= '0;
				if (in_close) begin
					rem_q  <= phase_q[beg_pkg::LID_W-1:0];
					open_q <= 1'b0;
				end else begin
					rem_q  <= open_x[beg_pkg::LID_W-1:0];
					open_q <= 1'b1;
				end
				if (stat.hold) begin
					closure_q <= beg_pkg::LID_FULL;
				end
			end
			beg_pkg::OP_DIV: begin
				rem_q  <= ge ? diff[beg_pkg::LID_W-1:0] : shifted[beg_pkg::LID_W-1:0];
				quot_q <= {quot_q[beg_pkg::LID_W-2:0], ge};
				cnt_q  <= cnt_q + 4'd1;
			end
			beg_pkg::OP_FIN: begin
				// The reopening ramp is one minus the quotient, clamped at full closure.
				if (open_q) begin
					closure_q <= (quot_q == '0) ? beg_pkg::LID_FULL : neg_q;
				end else begin
					closure_q <= quot_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Result word: each lid not driven by a clip takes the larger weight.
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			lout_q      <= (ldrv_q || (left_q >= closure_q)) ? left_q : closure_q;
			rout_q      <= (rdrv_q || (right_q >= closure_q)) ? right_q : closure_q;
			cout_q      <= closure_q;
			blink_out_q <= in_blink_q;
			active_q    <= closure_q != '0;
		end
	end

	assign left_lid_out  = lout_q;
	assign right_lid_out = rout_q;
	assign closure       = cout_q;
	assign blinking      = blink_out_q;
	assign made_active   = active_q;

endmodule

`default_nettype wire

// ===== rtl/blink_envelope_generator.sv =====
// Top level of the blink envelope generator: microcode sequencer, handshakes, registers.
//
// Input channel (in_valid, in_stall): one word per animation step with delta_ticks, both
// lid weights and both clip-driven flags. Output channel (out_valid, out_stall): one
// result word per input word, in order. Configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) writes register cfg_index; indexes past the list are ignored.
// A step runs a microprogram from a read-only table: advance, end check, ramp setup,
// a 16-step serial divider for the ramp and the output load. With no blink running the
// result is loaded after the end and blink checks; during the hold after the ramp setup
// too; on a ramp after the divider loop and its finish word as well; and when a blink ends
// after a new idle interval is drawn (xorshift, 24x24 multiply, add). A return word then
// brings the sequencer back to its idle word. One word is in flight at a time; the next
// is taken once the sequencer is back at its idle word, even while the previous result
// still waits. At reset the registers take their defaults and the sequencer draws the
// first idle interval before taking words. A seed write redraws the interval likewise.
// While the receiver stalls, the result holds and a finished step waits at its
// output load; input is stalled while a step runs or a configuration write is offered.
`default_nettype none
`include "assert_macros.svh"

module blink_envelope_generator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [beg_pkg::TICK_W-1:0]    delta_ticks,
	input  wire logic [beg_pkg::LID_W-1:0]     left_lid_in,
	input  wire logic [beg_pkg::LID_W-1:0]     right_lid_in,
	input  wire logic                          left_clip_driven,
	input  wire logic                          right_clip_driven,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [beg_pkg::LID_W-1:0]          left_lid_out,
	output logic [beg_pkg::LID_W-1:0]          right_lid_out,
	output logic [beg_pkg::LID_W-1:0]          closure,
	output logic                               blinking,
	output logic                               made_active,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire beg_pkg::cfg_idx_t             cfg_index,
	input  wire logic [beg_pkg::RNG_W-1:0]     cfg_data
);

	beg_pkg::pc_t    pc_q;
	beg_pkg::pc_t    pc_next;
	beg_pkg::ucode_t word;
	beg_pkg::cfg_t   cfg_q;
	beg_pkg::ctrl_t  ctrl;
	beg_pkg::stat_t  stat;
	logic            item_q;
	logic            out_valid_q;
	logic            out_free;
	logic            in_acc;
	logic            cfg_wr;
	logic            seed_wr;
	logic            jump;

	// Handshakes.
	assign cfg_ready = pc_q == beg_pkg::ADDR_IDLE;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign seed_wr   = cfg_wr && (cfg_index == beg_pkg::CFG_SEED);
	assign in_stall  = (pc_q != beg_pkg::ADDR_IDLE) || cfg_valid;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Current control word.
	assign word = beg_pkg::ucode_rom(pc_q);

	// Jump condition of the current word.
	always_comb begin
		case (word.cond)
			beg_pkg::C_NEVER:   jump = 1'b0;
			beg_pkg::C_ALWAYS:  jump = 1'b1;
			beg_pkg::C_END:     jump = stat.end_blink;
			beg_pkg::C_NOBLINK: jump = !stat.in_blink;
			beg_pkg::C_HOLD:    jump = stat.hold;
			beg_pkg::C_DIVMORE: jump = stat.div_more;
			beg_pkg::C_OUTBUSY: jump = !out_free;
			beg_pkg::C_ITEM:    jump = item_q;
			default:            jump = 1'b0;
		endcase
	end

	// Next step: the idle word dispatches, other words jump or fall through.
	always_comb begin
		if (word.op == beg_pkg::OP_IDLE) begin
			if (seed_wr) begin
				pc_next = beg_pkg::ADDR_XS;
			end else if (in_acc) begin
				pc_next = beg_pkg::ADDR_ADV;
			end else begin
				pc_next = pc_q;
			end
		end else if (jump) begin
			pc_next = word.target;
		end else begin
			pc_next = pc_q + 4'd1;
		end
	end

	// Datapath controls.
	always_comb begin
		ctrl.op        = word.op;
		ctrl.out_load  = (word.op == beg_pkg::OP_OUT) && out_free;
		ctrl.in_load   = in_acc;
		ctrl.seed_load = seed_wr;
		ctrl.abort     = cfg_wr && (cfg_index == beg_pkg::CFG_ENABLE) && !cfg_data[0];
		ctrl.seed      = cfg_data;
	end

	// Step counter, item flag and output valid. Reset starts with an interval draw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= beg_pkg::ADDR_XS;
			item_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (in_acc) begin
				item_q <= 1'b1;
			end else if (ctrl.out_load) begin
				item_q <= 1'b0;
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable  <= 1'b1;
			cfg_q.min_ivl <= beg_pkg::RST_MIN;
			cfg_q.span    <= beg_pkg::RST_SPAN;
			cfg_q.close_t <= beg_pkg::RST_CLOSE;
			cfg_q.hold_t  <= beg_pkg::RST_HOLD;
			cfg_q.open_t  <= beg_pkg::RST_OPEN;
		end else if (cfg_wr) begin
			case (cfg_index)
				beg_pkg::CFG_ENABLE: cfg_q.enable  <= cfg_data[0];
				beg_pkg::CFG_MIN:    cfg_q.min_ivl <= cfg_data[beg_pkg::IVL_W-1:0];
				beg_pkg::CFG_SPAN:   cfg_q.span    <= cfg_data[beg_pkg::IVL_W-1:0];
				beg_pkg::CFG_CLOSE:  cfg_q.close_t <= cfg_data[beg_pkg::TICK_W-1:0];
				beg_pkg::CFG_HOLD:   cfg_q.hold_t  <= cfg_data[beg_pkg::TICK_W-1:0];
				beg_pkg::CFG_OPEN:   cfg_q.open_t  <= cfg_data[beg_pkg::TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	beg_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.cfg               (cfg_q),
		.delta_ticks       (delta_ticks),
		.left_lid_in       (left_lid_in),
		.right_lid_in      (right_lid_in),
		.left_clip_driven  (left_clip_driven),
		.right_clip_driven (right_clip_driven),
		.stat              (stat),
		.left_lid_out      (left_lid_out),
		.right_lid_out     (right_lid_out),
		.closure           (closure),
		.blinking          (blinking),
		.made_active       (made_active)
	);

	// An accepted word always starts the step program.
	`ASSERT_NEXT(a_step_entry, clk, arst_n, in_acc, pc_q == beg_pkg::ADDR_ADV)
	// A result only appears from the output load word.
	`ASSERT_IMPLY(a_out_source, clk, arst_n, $rose(out_valid_q), $past(pc_q) == beg_pkg::ADDR_OUT)
	// A running blink requires blinking to be enabled.
	`ASSERT_IMPLY(a_blink_enabled, clk, arst_n, stat.in_blink, cfg_q.enable)

endmodule

`default_nettype wire
